@@ design/fsw_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the fade sequencer watchdog.
package fsw_pkg;

    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_FADE_IN  = 3'd1;
    localparam logic [2:0] PH_HOLD     = 3'd2;
    localparam logic [2:0] PH_FADE_OUT = 3'd3;
    localparam logic [2:0] PH_DONE     = 3'd4;

    localparam logic [2:0] ST_RUN      = 3'd0;
    localparam logic [2:0] ST_COMPLETE = 3'd1;
    localparam logic [2:0] ST_STALL    = 3'd2;
    localparam logic [2:0] ST_BUDGET   = 3'd3;
    localparam logic [2:0] ST_IGNORED  = 3'd4;

    localparam logic OP_START  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [2:0] CFG_FADE_MS    = 3'd0;
    localparam logic [2:0] CFG_HOLD_MS    = 3'd1;
    localparam logic [2:0] CFG_BUDGET_MS  = 3'd2;
    localparam logic [2:0] CFG_STALL_LIM  = 3'd3;
    localparam logic [2:0] CFG_ITER_LIM   = 3'd4;
    localparam logic [2:0] CFG_RENDER_LIM = 3'd5;

    localparam logic [15:0] RST_FADE_MS    = 16'd500;
    localparam logic [15:0] RST_HOLD_MS    = 16'd2000;
    localparam logic [19:0] RST_BUDGET_MS  = 20'd10000;
    localparam logic [19:0] RST_STALL_LIM  = 20'd20000;
    localparam logic [23:0] RST_ITER_LIM   = 24'd10000000;
    localparam logic [7:0]  RST_RENDER_LIM = 8'd32;

    localparam int unsigned DEGRADE_MIN_MS = 10000;
    localparam logic [3:0]  LEVEL_FULL     = 4'd10;

    typedef struct packed {
        logic       load;
        logic       samp;
        logic       te;
        logic       elap;
        logic       check;
        logic       prep;
        logic       div;
        logic [1:0] div_idx;
        logic       commit;
    } cmd_t;

    typedef struct packed {
        logic op_sample;
        logic running;
        logic skip_div;
    } stat_t;

    typedef struct packed {
        logic [6:0] opa;
        logic       draw;
        logic       clr;
        logic [2:0] phase;
        logic [2:0] status;
    } res_t;

endpackage

@@ design/fsw_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencing state machine of the fade sequencer watchdog.
module fsw_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  fsw_pkg::stat_t stat,
    output fsw_pkg::cmd_t  cmd
);
    import fsw_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_SAMP   = 4'd2;
    localparam logic [3:0] S_TE     = 4'd3;
    localparam logic [3:0] S_ELAP   = 4'd4;
    localparam logic [3:0] S_CHECK  = 4'd5;
    localparam logic [3:0] S_PREP   = 4'd6;
    localparam logic [3:0] S_DIV    = 4'd7;
    localparam logic [3:0] S_FIN    = 4'd8;

    logic [3:0] state_reg, state_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;
    logic       slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.div_idx    = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = in_valid;
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = (stat.op_sample && stat.running) ? S_SAMP : S_FIN;
            end
            S_SAMP:
            begin
                cmd.samp   = 1'b1;
                state_next = S_TE;
            end
            S_TE:
            begin
                cmd.te     = 1'b1;
                state_next = S_ELAP;
            end
            S_ELAP:
            begin
                cmd.elap   = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = S_PREP;
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                cnt_next   = 2'd3;
                state_next = stat.skip_div ? S_FIN : S_DIV;
            end
            S_DIV:
            begin
                cmd.div  = 1'b1;
                cnt_next = cnt_reg - 2'd1;
                if (cnt_reg == 2'd0)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (slot_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ design/fsw_datapath.sv @@
`timescale 1ns / 1ps
// Timing, watchdog and opacity datapath of the fade sequencer watchdog.
module fsw_datapath #(
    parameter int TIME_BITS = 48
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [23:0]          cfg_data,
    input  logic                 in_op,
    input  logic [TIME_BITS-1:0] in_now,
    input  logic [TIME_BITS-1:0] in_tc,
    input  logic                 in_ok,
    input  fsw_pkg::cmd_t        cmd,
    output fsw_pkg::stat_t       stat,
    output fsw_pkg::res_t        res
);
    import fsw_pkg::*;

    logic [15:0] fade_ms_reg, hold_ms_reg;
    logic [19:0] budget_reg, stall_lim_reg;
    logic [23:0] iter_lim_reg;
    logic [7:0]  render_lim_reg;

    logic                 op_reg, ok_reg;
    logic [TIME_BITS-1:0] now_reg, tc_reg;

    logic [2:0]           phase_reg;
    logic [TIME_BITS-1:0] clock_start_reg, ticks_start_reg, last_clock_reg, last_tick_reg;
    logic [TIME_BITS-1:0] elapsed_reg, phase_begin_reg, me_reg, te_reg, pe_reg;
    logic [19:0]          stall_reg;
    logic [23:0]          sample_reg;
    logic [7:0]           draw_cnt_reg;
    logic [3:0]           last_lvl_reg;
    logic                 last_valid_reg;
    logic                 budget_abort_reg, stall_abort_reg;
    logic                 pe_ge_fade_reg, pe_ge_hold_reg;
    logic [19:0]          rem_reg;
    logic [3:0]           quot_reg;
    res_t                 res_reg;

    logic [TIME_BITS-1:0] ticks;
    logic                 prog;
    logic [TIME_BITS:0]   me_diff, te_diff, pe_diff;
    logic [15:0]          b_val;
    logic [19:0]          num;
    logic [19:0]          div_sub;
    logic [20:0]          div_diff;
    logic                 running;
    logic                 degraded;
    logic [3:0]           lvl, o_lvl;
    logic                 draw_now, pe_ge;
    logic [6:0]           o_pct;
    res_t                 res_next;

    assign running = (phase_reg == PH_FADE_IN) || (phase_reg == PH_HOLD)
                     || (phase_reg == PH_FADE_OUT);

    assign stat.op_sample = (op_reg == OP_SAMPLE);
    assign stat.running   = running;
    assign stat.skip_div  = budget_abort_reg || stall_abort_reg || (phase_reg == PH_HOLD)
                            || (fade_ms_reg == 16'd0);

    assign ticks   = ok_reg ? tc_reg : last_tick_reg;
    assign prog    = (now_reg > last_clock_reg) || (ticks > last_tick_reg);
    assign me_diff = {1'b0, now_reg} - {1'b0, clock_start_reg};
    assign te_diff = {1'b0, last_tick_reg} - {1'b0, ticks_start_reg};
    assign pe_diff = {1'b0, elapsed_reg} - {1'b0, phase_begin_reg};

    assign b_val = (pe_reg > TIME_BITS'(fade_ms_reg)) ? fade_ms_reg : pe_reg[15:0];
    assign num   = {1'b0, b_val, 3'b000} + {3'b000, b_val, 1'b0};

    assign div_sub  = 20'(fade_ms_reg) << cmd.div_idx;
    assign div_diff = {1'b0, rem_reg} - {1'b0, div_sub};

    assign degraded = (now_reg >= TIME_BITS'(DEGRADE_MIN_MS))
                      && (tc_reg < (now_reg >> 2));

    assign lvl      = (fade_ms_reg == 16'd0) ? LEVEL_FULL : quot_reg;
    assign o_lvl    = (phase_reg == PH_FADE_IN) ? lvl : (LEVEL_FULL - lvl);
    assign draw_now = (phase_reg != PH_HOLD) && (!last_valid_reg || (o_lvl != last_lvl_reg));
    assign pe_ge    = (phase_reg == PH_HOLD) ? pe_ge_hold_reg : pe_ge_fade_reg;
    assign o_pct    = {o_lvl, 3'b000} + {2'b00, o_lvl, 1'b0};

    always_comb
    begin
        res_next        = '0;
        res_next.status = ST_RUN;
        res_next.phase  = phase_reg;
        if (op_reg == OP_START)
        begin
            if (!ok_reg || degraded)
            begin
                res_next.status = ST_BUDGET;
                res_next.phase  = PH_DONE;
            end
            else
            begin
                res_next.clr   = 1'b1;
                res_next.phase = PH_FADE_IN;
            end
        end
        else if (!running)
        begin
            res_next.status = ST_IGNORED;
        end
        else if (budget_abort_reg)
        begin
            res_next.status = ST_BUDGET;
            res_next.phase  = PH_DONE;
        end
        else if (stall_abort_reg)
        begin
            res_next.status = ST_STALL;
            res_next.phase  = PH_DONE;
        end
        else
        begin
            if (draw_now)
            begin
                res_next.draw = 1'b1;
                res_next.opa  = o_pct;
            end
            if (pe_ge)
            begin
                if (phase_reg == PH_FADE_OUT)
                begin
                    res_next.status = ST_COMPLETE;
                    res_next.phase  = PH_DONE;
                end
                else
                begin
                    res_next.phase = phase_reg + 3'd1;
                end
            end
        end
    end

    assign res = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fade_ms_reg    <= RST_FADE_MS;
            hold_ms_reg    <= RST_HOLD_MS;
            budget_reg     <= RST_BUDGET_MS;
            stall_lim_reg  <= RST_STALL_LIM;
            iter_lim_reg   <= RST_ITER_LIM;
            render_lim_reg <= RST_RENDER_LIM;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FADE_MS:    fade_ms_reg    <= cfg_data[15:0];
                CFG_HOLD_MS:    hold_ms_reg    <= cfg_data[15:0];
                CFG_BUDGET_MS:  budget_reg     <= cfg_data[19:0];
                CFG_STALL_LIM:  stall_lim_reg  <= cfg_data[19:0];
                CFG_ITER_LIM:   iter_lim_reg   <= cfg_data[23:0];
                CFG_RENDER_LIM: render_lim_reg <= cfg_data[7:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg           <= OP_START;
            ok_reg           <= 1'b0;
            now_reg          <= '0;
            tc_reg           <= '0;
            phase_reg        <= PH_IDLE;
            clock_start_reg  <= '0;
            ticks_start_reg  <= '0;
            last_clock_reg   <= '0;
            last_tick_reg    <= '0;
            elapsed_reg      <= '0;
            phase_begin_reg  <= '0;
            me_reg           <= '0;
            te_reg           <= '0;
            pe_reg           <= '0;
            stall_reg        <= '0;
            sample_reg       <= '0;
            draw_cnt_reg     <= '0;
            last_lvl_reg     <= '0;
            last_valid_reg   <= 1'b0;
            budget_abort_reg <= 1'b0;
            stall_abort_reg  <= 1'b0;
            pe_ge_fade_reg   <= 1'b0;
            pe_ge_hold_reg   <= 1'b0;
            rem_reg          <= '0;
            quot_reg         <= '0;
            res_reg          <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                op_reg           <= in_op;
                ok_reg           <= in_ok;
                now_reg          <= in_now;
                tc_reg           <= in_tc;
                budget_abort_reg <= 1'b0;
                stall_abort_reg  <= 1'b0;
            end
            if (cmd.samp)
            begin
                stall_reg      <= prog ? 20'd0 : (stall_reg + {19'd0, ~&stall_reg});
                sample_reg     <= sample_reg + {23'd0, ~&sample_reg};
                last_clock_reg <= now_reg;
                last_tick_reg  <= ticks;
                me_reg         <= me_diff[TIME_BITS] ? '0 : me_diff[TIME_BITS-1:0];
            end
            if (cmd.te)
            begin
                te_reg <= te_diff[TIME_BITS] ? '0 : te_diff[TIME_BITS-1:0];
            end
            if (cmd.elap)
            begin
                elapsed_reg <= (me_reg > te_reg) ? me_reg : te_reg;
            end
            if (cmd.check)
            begin
                budget_abort_reg <= (elapsed_reg > TIME_BITS'(budget_reg))
                                    || (sample_reg >= iter_lim_reg)
                                    || (draw_cnt_reg >= render_lim_reg);
                stall_abort_reg  <= (stall_reg >= stall_lim_reg);
                pe_reg           <= pe_diff[TIME_BITS] ? '0 : pe_diff[TIME_BITS-1:0];
            end
            if (cmd.prep)
            begin
                pe_ge_fade_reg <= (pe_reg >= TIME_BITS'(fade_ms_reg));
                pe_ge_hold_reg <= (pe_reg >= TIME_BITS'(hold_ms_reg));
                rem_reg        <= num;
                quot_reg       <= '0;
            end
            if (cmd.div)
            begin
                if (!div_diff[20])
                begin
                    rem_reg                <= div_diff[19:0];
                    quot_reg[cmd.div_idx] <= 1'b1;
                end
            end
            if (cmd.commit)
            begin
                res_reg <= res_next;
                if (op_reg == OP_START)
                begin
                    phase_reg       <= res_next.phase;
                    clock_start_reg <= now_reg;
                    last_clock_reg  <= now_reg;
                    ticks_start_reg <= ok_reg ? tc_reg : '0;
                    last_tick_reg   <= ok_reg ? tc_reg : '0;
                    elapsed_reg     <= '0;
                    phase_begin_reg <= '0;
                    stall_reg       <= '0;
                    sample_reg      <= '0;
                    draw_cnt_reg    <= '0;
                    last_lvl_reg    <= '0;
                    last_valid_reg  <= 1'b0;
                end
                else if (running)
                begin
                    phase_reg <= res_next.phase;
                    if (!budget_abort_reg && !stall_abort_reg)
                    begin
                        if (draw_now)
                        begin
                            draw_cnt_reg <= draw_cnt_reg + 8'd1;
                        end
                        if (pe_ge && (phase_reg != PH_FADE_OUT))
                        begin
                            phase_begin_reg <= elapsed_reg;
                            last_lvl_reg    <= '0;
                            last_valid_reg  <= 1'b0;
                        end
                        else if (draw_now)
                        begin
                            last_lvl_reg   <= o_lvl;
                            last_valid_reg <= 1'b1;
                        end
                    end
                end
            end
        end
    end

endmodule

@@ design/fade_sequencer_watchdog_unit.sv @@
`timescale 1ns / 1ps
// Top level of the fade sequencer watchdog: ports, controller and datapath.
// One result item leaves for every input item. A start item, or a sample that
// arrives while idle or finished, only decodes and finishes; a running sample
// also passes the sample, tick, elapsed, check and prepare steps of the 48-bit
// subtract and compare chain of the elapsed-time path and the four-step
// restoring divider for the opacity level, skipped on an abort, in the hold
// phase or when fade_ms is zero. A waiting result does not block acceptance
// of the next item; the final step of that item holds until the output
// register is free. Write configuration only while no item is in flight.
module fade_sequencer_watchdog_unit #(
    parameter int TIME_BITS = 48,
    localparam int S_TDATA_W = ((2 * TIME_BITS + 1 + 7) / 8) * 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // now_ms, tick_count, tick_source_ok, zeros
    input  logic                 s_axis_tuser,  // operation
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [15:0]          m_axis_tdata,  // status, phase_now, screen_clear, draw,
                                                // opacity, zero
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [23:0]          cfg_data
);
    import fsw_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    res_t  res;

    assign cfg_ready = 1'b1;

    fsw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    fsw_datapath #(
        .TIME_BITS (TIME_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_op     (s_axis_tuser),
        .in_now    (s_axis_tdata[TIME_BITS-1:0]),
        .in_tc     (s_axis_tdata[2*TIME_BITS-1:TIME_BITS]),
        .in_ok     (s_axis_tdata[2*TIME_BITS]),
        .cmd       (cmd),
        .stat      (stat),
        .res       (res)
    );

    assign m_axis_tdata = {1'b0, res};

`ifndef SYNTHESIS
    a_opacity_range : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (res.opa <= 7'd100))
        else $error("opacity above full scale");

    a_draw_quiet : assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !res.draw) |-> (res.opa == 7'd0))
        else $error("opacity set without a draw");

    a_clear_start : assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && res.clr) |-> (res.phase == PH_FADE_IN && res.status == ST_RUN))
        else $error("clear screen outside a successful start");

    a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while an item is in progress");
`endif

endmodule
